@@ hdl/amc_pkg.sv @@
// ----------------------------------------------------------------------------
// amc_pkg
// shared types, constants and helpers of the multi-pattern match counter
// ----------------------------------------------------------------------------
`default_nettype none

package amc_pkg;

   localparam int NODE_W  = 16;
   localparam int NODES   = 1 << NODE_W;
   localparam int CNT_W   = 17;
   localparam int ALPHA   = 26;
   localparam int SYM_W   = 5;
   localparam int ROW_W   = ALPHA * NODE_W;
   localparam int TOTAL_W = 32;

   localparam logic [1:0] KIND_PATTERN = 2'd0;
   localparam logic [1:0] KIND_BUILD   = 2'd1;
   localparam logic [1:0] KIND_TEXT    = 2'd2;

   localparam logic [NODE_W-1:0] ROOT    = '0;
   localparam logic [NODE_W-1:0] END_MAX = '1;

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [SYM_W-1:0]  sym_type;
   typedef logic [ROW_W-1:0]  row_type;

   typedef struct packed {
      logic     we;
      logic     clr;
      node_type addr;
      sym_type  lane;
      node_type data;
   } child_wr_type;

   function automatic node_type row_lane(row_type row, sym_type s);
      node_type r;
      r = ROOT;
      if (s < SYM_W'(ALPHA)) begin
         r = row[s*NODE_W +: NODE_W];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ hdl/amc_ram.sv @@
// ----------------------------------------------------------------------------
// amc_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module amc_ram #(
   parameter int AW = 16,
   parameter int DW = 16
) (
   input  wire logic          clock,
   input  wire logic          we,
   input  wire logic [AW-1:0] waddr,
   input  wire logic [DW-1:0] wdata,
   input  wire logic [AW-1:0] raddr,
   output logic      [DW-1:0] rdata
);

   logic [DW-1:0] mem [1 << AW];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

@@ hdl/amc_child_ram.sv @@
// ----------------------------------------------------------------------------
// amc_child_ram
// trie goto table, one row of child pointers per node, lane write or row clear
// ----------------------------------------------------------------------------
`default_nettype none

module amc_child_ram (
   input  wire logic                  clock,
   input  wire amc_pkg::child_wr_type wr,
   input  wire amc_pkg::node_type     raddr,
   output amc_pkg::row_type           rdata
);
   import amc_pkg::*;

   row_type mem [NODES];

   always_ff @(posedge clock) begin
      if (wr.we) begin
         if (wr.clr) begin
            mem[wr.addr] <= '0;
         end else begin
            mem[wr.addr][wr.lane*NODE_W +: NODE_W] <= wr.data;
         end
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

@@ hdl/multi_pattern_match_counter.sv @@
// ----------------------------------------------------------------------------
// multi_pattern_match_counter
// aho-corasick matcher: trie insert, breadth-first failure links, text count
// ----------------------------------------------------------------------------
// channel  dir  tdata                         tuser   tlast
// req      in   [1:0] kind, [6:2] symbol      -       is_last
// rsp      out  [31:0] match_count            status  last_echo
//
// pattern letter: a goto lookup that may add a node; text letter: walks the goto
//   lanes along failure links, then adds the end count of each node on the
//   output chain; build: scans the root lanes, then the lanes of each queued
//   node, and walks the failure links for each child; unknown kind: no table work
// every step goes through one sequencer and the single read port of each ram
// after reset the init state clears the root row; req_tready is low meanwhile
// one result register: the next beat is taken while a result waits
// ----------------------------------------------------------------------------
`default_nettype none

module multi_pattern_match_counter (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // kind[1:0], symbol[6:2], zero[7]
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // match_count[31:0]
   output logic             rsp_tuser,   // status
   output logic             rsp_tlast
);
   import amc_pkg::*;

   localparam logic [4:0] S_INIT    = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_P_RD    = 5'd2;
   localparam logic [4:0] S_P_NEW   = 5'd3;
   localparam logic [4:0] S_P_CLOSE = 5'd4;
   localparam logic [4:0] S_P_INC   = 5'd5;
   localparam logic [4:0] S_B_ROOT  = 5'd6;
   localparam logic [4:0] S_B_POP   = 5'd7;
   localparam logic [4:0] S_B_X     = 5'd8;
   localparam logic [4:0] S_B_ROWX  = 5'd9;
   localparam logic [4:0] S_B_S     = 5'd10;
   localparam logic [4:0] S_B_W     = 5'd11;
   localparam logic [4:0] S_B_WR    = 5'd12;
   localparam logic [4:0] S_B_E     = 5'd13;
   localparam logic [4:0] S_B_SET   = 5'd14;
   localparam logic [4:0] S_T_W     = 5'd15;
   localparam logic [4:0] S_T_WR    = 5'd16;
   localparam logic [4:0] S_T_E     = 5'd17;
   localparam logic [4:0] S_T_C     = 5'd18;
   localparam logic [4:0] S_T_A     = 5'd19;
   localparam logic [4:0] S_DONE    = 5'd20;

   logic [4:0]         state_ff, state_in;
   logic [1:0]         kind_ff, kind_in;
   sym_type            sym_ff, sym_in;
   logic               last_ff, last_in;
   logic               status_ff, status_in;
   node_type           ins_ff, ins_in;
   node_type           mcur_ff, mcur_in;
   node_type           cur_ff, cur_in;
   node_type           y_ff, y_in;
   node_type           fx_ff, fx_in;
   row_type            xrow_ff, xrow_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]   head_ff, head_in;
   logic [CNT_W-1:0]   tail_ff, tail_in;
   sym_type            s_ff, s_in;
   logic               rv_ff, rv_in;
   logic [TOTAL_W-1:0] rcount_ff, rcount_in;
   logic               rstat_ff, rstat_in;
   logic               rlast_ff, rlast_in;

   child_wr_type       cw;
   node_type           c_raddr;
   row_type            c_rdata;
   logic               f_we;
   node_type           f_waddr, f_wdata, f_raddr, f_rdata;
   logic               e_we;
   node_type           e_waddr, e_wdata, e_raddr, e_rdata;
   logic               q_we;
   node_type           q_waddr, q_wdata, q_raddr, q_rdata;

   sym_type            req_sym;
   node_type           lane_c;
   node_type           lane_x;
   logic [TOTAL_W:0]   sum;

   assign req_sym = req_tdata[6:2];
   assign lane_c  = row_lane(c_rdata, (state_ff == S_P_RD || state_ff == S_T_WR ||
                                       state_ff == S_T_E) ? sym_ff : s_ff);
   assign lane_x  = row_lane(xrow_ff, s_ff);
   assign sum     = {1'b0, total_ff} + (TOTAL_W + 1)'(e_rdata);

   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      sym_in    = sym_ff;
      last_in   = last_ff;
      status_in = status_ff;
      ins_in    = ins_ff;
      mcur_in   = mcur_ff;
      cur_in    = cur_ff;
      y_in      = y_ff;
      fx_in     = fx_ff;
      xrow_in   = xrow_ff;
      total_in  = total_ff;
      used_in   = used_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      s_in      = s_ff;
      rv_in     = rv_ff & ~rsp_tready;
      rcount_in = rcount_ff;
      rstat_in  = rstat_ff;
      rlast_in  = rlast_ff;
      cw        = '0;
      c_raddr   = ROOT;
      f_we      = 1'b0;
      f_waddr   = y_ff;
      f_wdata   = ROOT;
      f_raddr   = ROOT;
      e_we      = 1'b0;
      e_waddr   = ins_ff;
      e_wdata   = ROOT;
      e_raddr   = ROOT;
      q_we      = 1'b0;
      q_waddr   = tail_ff[NODE_W-1:0];
      q_wdata   = y_ff;
      q_raddr   = head_ff[NODE_W-1:0];

      unique case (state_ff)
         S_INIT: begin
            cw.we    = 1'b1;
            cw.clr   = 1'b1;
            cw.addr  = ROOT;
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in   = req_tdata[1:0];
               sym_in    = req_sym;
               last_in   = req_tlast;
               status_in = 1'b0;
               unique case (req_tdata[1:0])
                  KIND_PATTERN: begin
                     if (req_sym < SYM_W'(ALPHA)) begin
                        c_raddr  = ins_ff;
                        state_in = S_P_RD;
                     end else begin
                        state_in = S_P_CLOSE;
                     end
                  end
                  KIND_BUILD: begin
                     s_in     = '0;
                     head_in  = '0;
                     tail_in  = '0;
                     state_in = S_B_ROOT;
                  end
                  KIND_TEXT: begin
                     if (req_sym < SYM_W'(ALPHA)) begin
                        cur_in   = mcur_ff;
                        state_in = S_T_W;
                     end else begin
                        cur_in   = ROOT;
                        mcur_in  = ROOT;
                        state_in = S_T_C;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_P_RD: begin
            if (lane_c != ROOT) begin
               ins_in   = lane_c;
               state_in = S_P_CLOSE;
            end else if (used_ff >= CNT_W'(NODES)) begin
               status_in = 1'b1;
               state_in  = S_P_CLOSE;
            end else begin
               cw.we    = 1'b1;
               cw.addr  = ins_ff;
               cw.lane  = sym_ff;
               cw.data  = used_ff[NODE_W-1:0];
               f_we     = 1'b1;
               f_waddr  = used_ff[NODE_W-1:0];
               e_we     = 1'b1;
               e_waddr  = used_ff[NODE_W-1:0];
               state_in = S_P_NEW;
            end
         end
         S_P_NEW: begin
            cw.we    = 1'b1;
            cw.clr   = 1'b1;
            cw.addr  = used_ff[NODE_W-1:0];
            ins_in   = used_ff[NODE_W-1:0];
            used_in  = used_ff + 1'b1;
            state_in = S_P_CLOSE;
         end
         S_P_CLOSE: begin
            if (last_ff && ins_ff != ROOT) begin
               e_raddr  = ins_ff;
               state_in = S_P_INC;
            end else begin
               if (last_ff) begin
                  ins_in = ROOT;
               end
               state_in = S_DONE;
            end
         end
         S_P_INC: begin
            if (e_rdata != END_MAX) begin
               e_we    = 1'b1;
               e_wdata = e_rdata + 1'b1;
            end
            ins_in   = ROOT;
            state_in = S_DONE;
         end
         S_B_ROOT: begin
            if (lane_c != ROOT && tail_ff < CNT_W'(NODES)) begin
               f_we    = 1'b1;
               f_waddr = lane_c;
               q_we    = 1'b1;
               q_wdata = lane_c;
               tail_in = tail_ff + 1'b1;
            end
            if (s_ff == SYM_W'(ALPHA - 1)) begin
               state_in = S_B_POP;
            end else begin
               s_in = s_ff + 1'b1;
            end
         end
         S_B_POP: begin
            if (head_ff < tail_ff) begin
               state_in = S_B_X;
            end else begin
               state_in = S_DONE;
            end
         end
         S_B_X: begin
            head_in  = head_ff + 1'b1;
            c_raddr  = q_rdata;
            f_raddr  = q_rdata;
            state_in = S_B_ROWX;
         end
         S_B_ROWX: begin
            xrow_in  = c_rdata;
            fx_in    = f_rdata;
            s_in     = '0;
            state_in = S_B_S;
         end
         S_B_S: begin
            if (s_ff == SYM_W'(ALPHA)) begin
               state_in = S_B_POP;
            end else if (lane_x == ROOT) begin
               s_in = s_ff + 1'b1;
            end else begin
               y_in     = lane_x;
               cur_in   = fx_ff;
               state_in = S_B_W;
            end
         end
         S_B_W: begin
            c_raddr = cur_ff;
            f_raddr = cur_ff;
            if (cur_ff == ROOT) begin
               state_in = S_B_E;
            end else begin
               state_in = S_B_WR;
            end
         end
         S_B_WR: begin
            if (lane_c != ROOT) begin
               cur_in   = lane_c;
               state_in = S_B_SET;
            end else begin
               cur_in   = f_rdata;
               state_in = S_B_W;
            end
         end
         S_B_E: begin
            cur_in   = lane_c;
            state_in = S_B_SET;
         end
         S_B_SET: begin
            f_we    = 1'b1;
            f_wdata = (cur_ff == y_ff) ? ROOT : cur_ff;
            if (tail_ff < CNT_W'(NODES)) begin
               q_we    = 1'b1;
               tail_in = tail_ff + 1'b1;
            end
            s_in     = s_ff + 1'b1;
            state_in = S_B_S;
         end
         S_T_W: begin
            c_raddr = cur_ff;
            f_raddr = cur_ff;
            if (cur_ff == ROOT) begin
               state_in = S_T_E;
            end else begin
               state_in = S_T_WR;
            end
         end
         S_T_WR: begin
            if (lane_c != ROOT) begin
               cur_in   = lane_c;
               mcur_in  = lane_c;
               state_in = S_T_C;
            end else begin
               cur_in   = f_rdata;
               state_in = S_T_W;
            end
         end
         S_T_E: begin
            cur_in   = lane_c;
            mcur_in  = lane_c;
            state_in = S_T_C;
         end
         S_T_C: begin
            e_raddr = cur_ff;
            f_raddr = cur_ff;
            if (cur_ff == ROOT) begin
               state_in = S_DONE;
            end else begin
               state_in = S_T_A;
            end
         end
         S_T_A: begin
            total_in = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            cur_in   = f_rdata;
            state_in = S_T_C;
         end
         S_DONE: begin
            if (!rv_ff || rsp_tready) begin
               rv_in     = 1'b1;
               rcount_in = total_ff;
               rstat_in  = status_ff;
               rlast_in  = last_ff;
               if (kind_ff == KIND_TEXT && last_ff) begin
                  total_in = '0;
                  mcur_in  = ROOT;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
         ins_ff   <= ROOT;
         mcur_ff  <= ROOT;
         total_ff <= '0;
         used_ff  <= CNT_W'(1);
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         ins_ff   <= ins_in;
         mcur_ff  <= mcur_in;
         total_ff <= total_in;
         used_ff  <= used_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      sym_ff    <= sym_in;
      last_ff   <= last_in;
      status_ff <= status_in;
      cur_ff    <= cur_in;
      y_ff      <= y_in;
      fx_ff     <= fx_in;
      xrow_ff   <= xrow_in;
      head_ff   <= head_in;
      tail_ff   <= tail_in;
      s_ff      <= s_in;
      rcount_ff <= rcount_in;
      rstat_ff  <= rstat_in;
      rlast_ff  <= rlast_in;
   end

   amc_child_ram u_child (
      .clock (clock),
      .wr    (cw),
      .raddr (c_raddr),
      .rdata (c_rdata)
   );

   amc_ram #(.AW(NODE_W), .DW(NODE_W)) u_fail (
      .clock (clock),
      .we    (f_we),
      .waddr (f_waddr),
      .wdata (f_wdata),
      .raddr (f_raddr),
      .rdata (f_rdata)
   );

   amc_ram #(.AW(NODE_W), .DW(NODE_W)) u_end (
      .clock (clock),
      .we    (e_we),
      .waddr (e_waddr),
      .wdata (e_wdata),
      .raddr (e_raddr),
      .rdata (e_rdata)
   );

   amc_ram #(.AW(NODE_W), .DW(NODE_W)) u_queue (
      .clock (clock),
      .we    (q_we),
      .waddr (q_waddr),
      .wdata (q_wdata),
      .raddr (q_raddr),
      .rdata (q_rdata)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rcount_ff;
   assign rsp_tuser  = rstat_ff;
   assign rsp_tlast  = rlast_ff;

endmodule

`default_nettype wire

@@ hdl/amc_checker.sv @@
// ----------------------------------------------------------------------------
// amc_checker
// port-level checks of the multi-pattern match counter
// ----------------------------------------------------------------------------
`default_nettype none

module amc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [7:0]  req_tdata,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // one item in work at a time
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("beat accepted while busy");

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !req_tready)
      else $error("activity right after reset");

   // an accepted beat never yields a result in the next cycle unless one waited
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result appeared too early");

endmodule

bind multi_pattern_match_counter amc_checker u_amc_checker (.*);

`default_nettype wire

@@ bench/tb_multi_pattern_match_counter.sv @@
// ----------------------------------------------------------------------------
// tb_multi_pattern_match_counter
// random and directed beats against a trie/failure-link match count predictor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb_multi_pattern_match_counter;
   import amc_pkg::*;

   localparam int WATCH_LIMIT = 400000;

   typedef struct packed {
      logic [31:0] total;
      logic        status;
      logic        last;
   } rsp_beat_type;

   class match_scoreboard;
      int unsigned child[int];
      int unsigned fail[int];
      int unsigned ends[int];
      int unsigned used;
      int unsigned ins_cur;
      int unsigned txt_cur;
      logic [31:0] total;
      rsp_beat_type pending[$];
      int errors;

      function new();
         used = 1;
         ins_cur = 0;
         txt_cur = 0;
         total = 0;
         errors = 0;
         fail[0] = 0;
      endfunction

      function int unsigned go(int unsigned n, int unsigned s);
         if (s >= ALPHA || !child.exists(n * ALPHA + s)) return 0;
         return child[n * ALPHA + s];
      endfunction

      function int unsigned fl(int unsigned n);
         return fail.exists(n) ? fail[n] : 0;
      endfunction

      function int unsigned cnt(int unsigned n);
         return ends.exists(n) ? ends[n] : 0;
      endfunction

      function void build_links();
         int unsigned q[$];
         int unsigned x, y, f;
         fail[0] = 0;
         for (int s = 0; s < ALPHA; s++) begin
            y = go(0, s);
            if (y != 0) begin
               fail[y] = 0;
               q.push_back(y);
            end
         end
         while (q.size() > 0) begin
            x = q.pop_front();
            for (int s = 0; s < ALPHA; s++) begin
               y = go(x, s);
               if (y == 0) continue;
               f = fl(x);
               while (f != 0 && go(f, s) == 0) f = fl(f);
               f = go(f, s);
               fail[y] = (f == y) ? 0 : f;
               q.push_back(y);
            end
         end
      endfunction

      function void note_request(logic [1:0] kind, logic [4:0] sym, logic last);
         rsp_beat_type e;
         longint unsigned sum;
         int unsigned c, nx;
         e.status = 0;
         if (kind == KIND_PATTERN) begin
            if (sym < ALPHA) begin
               nx = go(ins_cur, sym);
               if (nx != 0) ins_cur = nx;
               else if (used >= NODES) e.status = 1;
               else begin
                  child[ins_cur * ALPHA + sym] = used;
                  fail[used] = 0;
                  ins_cur = used;
                  used++;
               end
            end
            if (last) begin
               if (ins_cur != 0 && cnt(ins_cur) < 65535) ends[ins_cur] = cnt(ins_cur) + 1;
               ins_cur = 0;
            end
         end else if (kind == KIND_BUILD) begin
            build_links();
         end else if (kind == KIND_TEXT) begin
            c = txt_cur;
            if (sym >= ALPHA) c = 0;
            else begin
               while (c != 0 && go(c, sym) == 0) c = fl(c);
               c = go(c, sym);
            end
            txt_cur = c;
            sum = total;
            while (c != 0) begin
               sum += cnt(c);
               if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
               c = fl(c);
            end
            total = sum[31:0];
         end
         e.total = total;
         e.last = last;
         if (kind == KIND_TEXT && last) begin
            total = 0;
            txt_cur = 0;
         end
         pending.push_back(e);
      endfunction

      function void check_result(logic [31:0] t, logic st, logic la);
         rsp_beat_type e;
         if (pending.size() == 0) begin
            $error("unexpected beat match_count %0d", t);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (t !== e.total) begin
            $error("match_count expected %0d actual %0d", e.total, t);
            errors++;
         end
         if (st !== e.status) begin
            $error("status expected %0d actual %0d", e.status, st);
            errors++;
         end
         if (la !== e.last) begin
            $error("last_echo expected %0d actual %0d", e.last, la);
            errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [7:0] req_tdata = '0;
   logic req_tlast = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   match_scoreboard board = new();
   int idle_cycles = 0;
   int sink_wait = 0;
   bit sink_stall_long = 0;
   string words[$];

   always #10 clock = ~clock;

   multi_pattern_match_counter dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            board.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
         if (sink_stall_long) begin
            rsp_tready <= 1;
         end else if (sink_wait > 0) begin
            rsp_tready <= 0;
            sink_wait <= sink_wait - 1;
         end else if ($urandom_range(0, 99) < 2) begin
            rsp_tready <= 0;
            sink_wait <= $urandom_range(10, 40);
         end else begin
            rsp_tready <= ($urandom_range(0, 99) < 70);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_beat(logic [1:0] kind, logic [4:0] sym, logic last);
      int gap;
      gap = pick_gap();
      repeat (gap + 1) @(posedge clock);
      req_tvalid <= 1;
      req_tdata <= {1'b0, sym, kind};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      board.note_request(kind, sym, last);
      req_tvalid <= 0;
   endtask

   task automatic send_word(string w, logic [1:0] kind, bit close);
      for (int i = 0; i < w.len(); i++)
         send_beat(kind, 5'(w[i] - 8'h61), close && (i == w.len() - 1));
   endtask

   task automatic drain();
      while (board.pending.size() > 0) @(posedge clock);
   endtask

   function automatic string rand_word(int maxlen);
      string w;
      int n;
      w = "";
      n = $urandom_range(1, maxlen);
      for (int i = 0; i < n; i++) w = {w, string'(8'(8'h61 + $urandom_range(0, 3)))};
      return w;
   endfunction

   initial begin
      int sent, n;
      string w;
      repeat (3) @(posedge clock);
      reset <= 0;

      // directed: patterns, odd symbols, build, unknown kind, text
      send_word("he", KIND_PATTERN, 1);
      send_word("she", KIND_PATTERN, 1);
      send_word("his", KIND_PATTERN, 1);
      send_word("hers", KIND_PATTERN, 1);
      send_beat(KIND_PATTERN, 5'd25, 0);
      send_beat(KIND_PATTERN, 5'd31, 1);
      send_beat(KIND_PATTERN, 5'd0, 1);
      send_beat(KIND_PATTERN, 5'd0, 1);
      send_beat(KIND_BUILD, 5'd31, 0);
      send_beat(2'd3, 5'd31, 1);
      send_word("ushers", KIND_TEXT, 0);
      send_beat(KIND_TEXT, 5'd31, 0);
      send_word("aa", KIND_TEXT, 0);
      send_beat(KIND_TEXT, 5'd0, 1);
      sent = 28;
      drain();

      sink_stall_long = 0;
      while (sent < 1950) begin
         if ($urandom_range(0, 9) == 0) begin
            drain();
            sink_stall_long = 1;
            repeat ($urandom_range(5, 30)) @(posedge clock);
            sink_stall_long = 0;
         end
         n = $urandom_range(1, 4);
         for (int i = 0; i < n; i++) begin
            w = rand_word(5);
            send_word(w, KIND_PATTERN, 1);
            sent += w.len();
         end
         if ($urandom_range(0, 5) != 0) begin
            send_beat(KIND_BUILD, 5'($urandom_range(0, 31)), 1'($urandom));
            sent++;
         end
         n = $urandom_range(4, 30);
         for (int i = 0; i < n; i++) begin
            int r;
            r = $urandom_range(0, 19);
            if (r == 0) send_beat(2'($urandom_range(0, 3)), 5'($urandom), 1'($urandom));
            else if (r == 1) send_beat(KIND_TEXT, 5'($urandom_range(26, 31)), 0);
            else send_beat(KIND_TEXT, 5'($urandom_range(0, 3)), i == n - 1);
            sent++;
         end
      end
      drain();
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
